@@ hdl/vtdi_pkg.sv @@
package vtdi_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} vtdi_state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
	} vtdi_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic last_issue;
		logic hit;
	} vtdi_sts_t;

	localparam int unsigned FIELD_BITS = 20;
	localparam int unsigned OUT_INDEX_BITS = 10;
	localparam int unsigned OUT_COUNT_BITS = 11;

endpackage

@@ hdl/vtdi_in_if.sv @@
interface vtdi_in_if;
	logic        valid;
	logic        ready;
	logic        first_corner;
	logic        last_corner;
	logic [19:0] pos_index;
	logic [19:0] uv_index;
	logic [19:0] normal_index;

	modport source (
		output valid, first_corner, last_corner, pos_index, uv_index, normal_index,
		input  ready
	);
	modport sink (
		input  valid, first_corner, last_corner, pos_index, uv_index, normal_index,
		output ready
	);
endinterface

@@ hdl/vtdi_out_if.sv @@
interface vtdi_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_index;
	logic        is_new;
	logic [10:0] distinct_count;
	logic        overflow;
	logic        done_res;

	modport source (
		output valid, out_index, is_new, distinct_count, overflow, done_res,
		input  ready
	);
	modport sink (
		input  valid, out_index, is_new, distinct_count, overflow, done_res,
		output ready
	);
endinterface

@@ hdl/vtdi_ram.sv @@
module vtdi_ram #(
	parameter int unsigned WIDTH = 60,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/vtdi_ctrl.sv @@
module vtdi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output vtdi_pkg::vtdi_cmd_t cmd,
	input  vtdi_pkg::vtdi_sts_t sts
);
	import vtdi_pkg::*;

	vtdi_state_t state_q;
	vtdi_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.count_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					if (sts.last_issue) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

@@ hdl/vtdi_datapath.sv @@
module vtdi_datapath #(
	parameter int unsigned MAX_DISTINCT = 1024,
	parameter int unsigned INDEX_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vtdi_pkg::vtdi_cmd_t cmd,
	output vtdi_pkg::vtdi_sts_t sts,
	input  logic                first_corner,
	input  logic                last_corner,
	input  logic [19:0]         pos_index,
	input  logic [19:0]         uv_index,
	input  logic [19:0]         normal_index,
	output logic [9:0]          out_index,
	output logic                is_new,
	output logic [10:0]         distinct_count,
	output logic                overflow,
	output logic                done_res
);
	import vtdi_pkg::*;

	localparam int unsigned KB = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
	localparam int unsigned EW = 3 * KB;
	localparam int unsigned AW = $clog2(MAX_DISTINCT);
	localparam int unsigned CW = $clog2(MAX_DISTINCT + 1);

	logic [EW-1:0] key_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] addr_q;
	logic          found_q;
	logic [AW-1:0] found_idx_q;
	logic          rvalid_s1;
	logic [AW-1:0] raddr_s1;
	logic [EW-1:0] rdata;

	logic          full;
	logic          wr_en;
	logic [AW-1:0] idx_sel;
	logic [CW-1:0] count_next;
	logic [31:0]   idx_ext;
	logic [31:0]   count_ext;
	logic          hit;

	logic [9:0]    out_index_q;
	logic          is_new_q;
	logic [10:0]   distinct_count_q;
	logic          overflow_q;
	logic          done_q;

	vtdi_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_DISTINCT)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (key_q),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign hit        = rvalid_s1 && (rdata == key_q);
	assign full       = (count_q == CW'(MAX_DISTINCT));
	assign wr_en      = cmd.commit && !found_q && !full;
	assign idx_sel    = found_q ? found_idx_q : (full ? '0 : count_q[AW-1:0]);
	assign count_next = wr_en ? count_q + CW'(1) : count_q;
	assign idx_ext    = 32'(idx_sel);
	assign count_ext  = 32'(count_next);

	assign sts.hit        = hit;
	assign sts.count_zero = (count_q == '0);
	assign sts.last_issue = (CW'(addr_q) == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
			found_q   <= 1'b0;
			addr_q    <= '0;
		end else begin
			rvalid_s1 <= cmd.rd_en;
			if (cmd.load) begin
				found_q <= 1'b0;
				addr_q  <= '0;
				if (first_corner) begin
					count_q <= '0;
				end
			end else begin
				if (cmd.rd_en) begin
					addr_q <= addr_q + AW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (cmd.commit) begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= {pos_index[KB-1:0], uv_index[KB-1:0], normal_index[KB-1:0]};
			last_q <= last_corner;
		end
		if (cmd.rd_en) begin
			raddr_s1 <= addr_q;
		end
		if (hit) begin
			found_idx_q <= raddr_s1;
		end
		if (cmd.commit) begin
			out_index_q      <= idx_ext[9:0];
			is_new_q         <= wr_en;
			distinct_count_q <= count_ext[10:0];
			overflow_q       <= !found_q && full;
			done_q           <= last_q;
		end
	end

	assign out_index      = out_index_q;
	assign is_new         = is_new_q;
	assign distinct_count = distinct_count_q;
	assign overflow       = overflow_q;
	assign done_res       = done_q;
endmodule

@@ hdl/vertex_triple_dedup_indexer_top.sv @@
// A corner request is taken only while idle; the scan then reads stored entries in
// order, one table entry per cycle, up to the stored count (at most MAX_DISTINCT),
// and stops on a match; an empty table is not read. The next corner is taken after
// the result is committed; a result left waiting holds the next scan in its final cycle until the result is taken.
// Reset: arst_n clears the controller, the stored count and the result valid;
// the table memory is not cleared, entries beyond the count are never read.
module vertex_triple_dedup_indexer_top #(
	parameter int unsigned MAX_DISTINCT = 1024,
	parameter int unsigned INDEX_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	vtdi_in_if.sink           corner,
	vtdi_out_if.source        result
);
	import vtdi_pkg::*;

	vtdi_cmd_t cmd;
	vtdi_sts_t sts;

	vtdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corner.valid),
		.in_ready  (corner.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	vtdi_datapath #(
		.MAX_DISTINCT (MAX_DISTINCT),
		.INDEX_BITS   (INDEX_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.first_corner   (corner.first_corner),
		.last_corner    (corner.last_corner),
		.pos_index      (corner.pos_index),
		.uv_index       (corner.uv_index),
		.normal_index   (corner.normal_index),
		.out_index      (result.out_index),
		.is_new         (result.is_new),
		.distinct_count (result.distinct_count),
		.overflow       (result.overflow),
		.done_res       (result.done_res)
	);
endmodule

@@ hdl/vtdi_checker.sv @@
module vtdi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  out_index,
	input logic        is_new,
	input logic [10:0] distinct_count,
	input logic        overflow,
	input logic        done_res
);
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("corner request taken while another is in flight");

	a_new_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && overflow))
		else $error("result both new and overflow");

	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new |-> out_index == 10'(distinct_count - 11'd1))
		else $error("new vertex index does not match count");

	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> out_index == 10'd0)
		else $error("overflow result carries nonzero index");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(is_new)
			&& $stable(distinct_count) && $stable(overflow) && $stable(done_res))
		else $error("stalled result changed");
endmodule

bind vertex_triple_dedup_indexer_top vtdi_checker u_vtdi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (corner.valid),
	.in_ready       (corner.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_index      (result.out_index),
	.is_new         (result.is_new),
	.distinct_count (result.distinct_count),
	.overflow       (result.overflow),
	.done_res       (result.done_res)
);
